// ===== rtl/clebsch_gordan_coefficient_macros.svh =====
// Assertion helpers for the RTL.
`ifndef CLEBSCH_GORDAN_COEFFICIENT_MACROS_SVH
`define CLEBSCH_GORDAN_COEFFICIENT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CGC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CGC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/cgc_pkg.sv =====
`default_nettype none

package cgc_pkg;

	localparam int DBL_W       = 64;
	localparam int FACT_DEPTH  = 64;
	localparam int FACT_AW     = $clog2(FACT_DEPTH);
	localparam logic [DBL_W-1:0] DBL_ONE = 64'h3FF0_0000_0000_0000;

	typedef enum logic [1:0] {
		FOP_MUL,
		FOP_DIV,
		FOP_ADD,
		FOP_SQRT
	} fop_t;

	typedef struct packed {
		logic go;
		fop_t op;
	} fpu_ctl_t;

	typedef struct packed {
		logic done;
		logic idle;
	} fpu_sts_t;

	typedef enum logic [3:0] {
		F_IDLE,
		F_MUL,
		F_PNORM,
		F_DIV,
		F_QNORM,
		F_SQRT,
		F_RNORM,
		F_ALIGN,
		F_ADD,
		F_ANORM,
		F_ROUND,
		F_DONE
	} fpu_st_t;

	typedef enum logic [2:0] {
		S_INIT_ZERO,
		S_INIT_GO,
		S_INIT_WAIT,
		S_IDLE,
		S_CHECK,
		S_FETCH,
		S_OPER,
		S_WAIT
	} seq_st_t;

	// Steps of the microprogram: Racah term, then normalization and final product.
	typedef enum logic [4:0] {
		P_T_N1,
		P_T_N2,
		P_T_NU,
		P_T_D1,
		P_T_D2,
		P_T_D3,
		P_T_DIV,
		P_T_ADD,
		P_N_INT,
		P_N_A,
		P_N_B,
		P_N_C,
		P_N_D,
		P_N_E,
		P_D_P,
		P_D_Q,
		P_D_R,
		P_D_S,
		P_D_T,
		P_N_DIV,
		P_N_SQRT,
		P_N_MUL
	} pc_t;

	typedef enum logic [2:0] {
		U_LDF,
		U_LDI,
		U_MULF,
		U_DIV,
		U_ADD,
		U_SQRT,
		U_MULS
	} uop_t;

endpackage

`default_nettype wire

// ===== rtl/cgc_ram.sv =====
`default_nettype none

module cgc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/cgc_fpu.sv =====
`default_nettype none

module cgc_fpu import cgc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire fpu_ctl_t         ctl,
	input  wire logic [DBL_W-1:0] opa,
	input  wire logic [DBL_W-1:0] opb,
	output fpu_sts_t              sts,
	output logic      [DBL_W-1:0] res
);

	fpu_st_t st_q, st_d;

	logic [105:0] prod_q;
	logic [52:0]  mq_q, den_q, mant_q;
	logic [57:0]  rem_q;
	logic [54:0]  q_q;
	logic [53:0]  rad_q;
	logic [55:0]  bigm_q, smallm_q;
	logic [56:0]  r_q;
	logic         sub_q, g_q, s_q, sign_q;
	logic signed [12:0] exp_q;
	logic [6:0]   cnt_q;
	logic [63:0]  res_q;

	logic         sa, sb, mzero, a_big, div_ge, sq_ge, e_odd, rnd_up;
	logic [10:0]  fa, fb, dexp;
	logic [52:0]  ma, mb;
	logic [53:0]  upper, div_diff, m54;
	logic [57:0]  rem_n, trial;
	logic [63:0]  big, small_op;
	logic signed [12:0] sq_e, sq_x, exp_r;

	always_comb begin
		sa       = opa[63];
		sb       = opb[63];
		fa       = opa[62:52];
		fb       = opb[62:52];
		ma       = {1'b1, opa[51:0]};
		mb       = {1'b1, opb[51:0]};
		mzero    = (fa == 11'd0) || (fb == 11'd0);
		a_big    = opa[62:0] >= opb[62:0];
		big      = a_big ? opa : opb;
		small_op = a_big ? opb : opa;
		dexp     = big[62:52] - small_op[62:52];
		e_odd    = ~fa[0];
		sq_e     = $signed({2'b0, fa}) - 13'sd1075 - $signed({12'b0, e_odd});
		sq_x     = sq_e - 13'sd54;
		upper    = {1'b0, prod_q[105:53]} + (mq_q[0] ? {1'b0, den_q} : 54'd0);
		div_ge   = rem_q[53:0] >= {1'b0, den_q};
		div_diff = div_ge ? rem_q[53:0] - {1'b0, den_q} : rem_q[53:0];
		rem_n    = {rem_q[55:0], rad_q[53:52]};
		trial    = {2'b0, q_q[53:0], 2'b01};
		sq_ge    = rem_n >= trial;
		rnd_up   = g_q & (s_q | mant_q[0]);
		m54      = {1'b0, mant_q} + {53'd0, rnd_up};
		exp_r    = exp_q + $signed({12'b0, m54[53]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= F_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			F_IDLE: begin
				if (ctl.go) begin
					unique case (ctl.op)
						FOP_MUL:  st_d = mzero ? F_DONE : F_MUL;
						FOP_DIV:  st_d = F_DIV;
						FOP_SQRT: st_d = F_SQRT;
						FOP_ADD:  st_d = mzero ? F_DONE : F_ALIGN;
						default:  st_d = F_IDLE;
					endcase
				end
			end
			F_MUL:   if (cnt_q == 7'd1) st_d = F_PNORM;
			F_DIV:   if (cnt_q == 7'd1) st_d = F_QNORM;
			F_SQRT:  if (cnt_q == 7'd1) st_d = F_RNORM;
			F_PNORM, F_QNORM, F_RNORM: st_d = F_ROUND;
			F_ALIGN: if (cnt_q == 7'd0) st_d = F_ADD;
			F_ADD:   st_d = F_ANORM;
			F_ANORM: begin
				if (r_q == 57'd0) begin
					st_d = F_DONE;
				end else if (!r_q[56] && r_q[55]) begin
					st_d = F_ROUND;
				end
			end
			F_ROUND: st_d = F_DONE;
			F_DONE:  st_d = F_IDLE;
			default: st_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (st_q)
			F_IDLE: begin
				if (ctl.go) begin
					case (ctl.op)
						FOP_MUL: begin
							sign_q <= sa ^ sb;
							exp_q  <= $signed({2'b0, fa}) + $signed({2'b0, fb}) - 13'sd1023;
							prod_q <= '0;
							mq_q   <= ma;
							den_q  <= mb;
							cnt_q  <= 7'd53;
							res_q  <= {sa ^ sb, 63'd0};
						end
						FOP_DIV: begin
							sign_q <= sa ^ sb;
							exp_q  <= $signed({2'b0, fa}) - $signed({2'b0, fb}) + 13'sd1023;
							rem_q  <= {5'd0, ma};
							den_q  <= mb;
							q_q    <= '0;
							cnt_q  <= 7'd55;
						end
						FOP_SQRT: begin
							sign_q <= 1'b0;
							exp_q  <= (sq_x >>> 1) + 13'sd1076;
							rad_q  <= e_odd ? {ma, 1'b0} : {1'b0, ma};
							rem_q  <= '0;
							q_q    <= '0;
							cnt_q  <= 7'd54;
						end
						default: begin
							// add: an operand of zero passes the other through
							res_q    <= (fa == 11'd0) ? opb : opa;
							sign_q   <= big[63];
							sub_q    <= sa ^ sb;
							exp_q    <= $signed({2'b0, big[62:52]});
							bigm_q   <= {1'b1, big[51:0], 3'b0};
							if (dexp >= 11'd58) begin
								smallm_q <= 56'd1;
								cnt_q    <= 7'd0;
							end else begin
								smallm_q <= {1'b1, small_op[51:0], 3'b0};
								cnt_q    <= dexp[6:0];
							end
						end
					endcase
				end
			end
			F_MUL: begin
				prod_q <= {upper, prod_q[52:1]};
				mq_q   <= {1'b0, mq_q[52:1]};
				cnt_q  <= cnt_q - 7'd1;
			end
			F_PNORM: begin
				if (prod_q[105]) begin
					mant_q <= prod_q[105:53];
					g_q    <= prod_q[52];
					s_q    <= |prod_q[51:0];
					exp_q  <= exp_q + 13'sd1;
				end else begin
					mant_q <= prod_q[104:52];
					g_q    <= prod_q[51];
					s_q    <= |prod_q[50:0];
				end
			end
			F_DIV: begin
				rem_q <= {4'd0, div_diff[52:0], 1'b0};
				q_q   <= {q_q[53:0], div_ge};
				cnt_q <= cnt_q - 7'd1;
			end
			F_QNORM: begin
				if (q_q[54]) begin
					mant_q <= q_q[54:2];
					g_q    <= q_q[1];
					s_q    <= q_q[0] | (|rem_q);
				end else begin
					mant_q <= q_q[53:1];
					g_q    <= q_q[0];
					s_q    <= |rem_q;
					exp_q  <= exp_q - 13'sd1;
				end
			end
			F_SQRT: begin
				rem_q <= sq_ge ? rem_n - trial : rem_n;
				q_q   <= {q_q[53:0], sq_ge};
				rad_q <= {rad_q[51:0], 2'b00};
				cnt_q <= cnt_q - 7'd1;
			end
			F_RNORM: begin
				mant_q <= q_q[53:1];
				g_q    <= q_q[0];
				s_q    <= |rem_q;
			end
			F_ALIGN: begin
				if (cnt_q != 7'd0) begin
					smallm_q <= {1'b0, smallm_q[55:2], smallm_q[1] | smallm_q[0]};
					cnt_q    <= cnt_q - 7'd1;
				end
			end
			F_ADD: begin
				r_q <= sub_q ? {1'b0, bigm_q} - {1'b0, smallm_q}
				             : {1'b0, bigm_q} + {1'b0, smallm_q};
			end
			F_ANORM: begin
				if (r_q == 57'd0) begin
					res_q <= '0;
				end else if (r_q[56]) begin
					r_q   <= {1'b0, r_q[56:2], r_q[1] | r_q[0]};
					exp_q <= exp_q + 13'sd1;
				end else if (!r_q[55]) begin
					r_q   <= {r_q[55:0], 1'b0};
					exp_q <= exp_q - 13'sd1;
				end else begin
					mant_q <= r_q[55:3];
					g_q    <= r_q[2];
					s_q    <= r_q[1] | r_q[0];
				end
			end
			F_ROUND: begin
				res_q <= {sign_q, exp_r[10:0], m54[53] ? 52'd0 : m54[51:0]};
			end
			default: begin
			end
		endcase
	end

	assign sts.done = (st_q == F_DONE);
	assign sts.idle = (st_q == F_IDLE);
	assign res      = res_q;

endmodule

`default_nettype wire

// ===== rtl/clebsch_gordan_coefficient.sv =====
`default_nettype none

// Clebsch-Gordan coefficient <j1 m1 j2 m2 | J M> by the Racah sum, returned as an
// IEEE double bit pattern. All six inputs are doubled values. Pulse start while busy
// is low; the inputs are sampled on that edge. The result shows on coefficient_bits
// for exactly one cycle with done high, and the block cannot be stalled, so capture
// it then. After reset the block builds its factorial table (0! to 63!) with its own
// multiplier and holds busy high until it is complete, before the first transaction.
// Inputs that break a selection rule return +0.0, with done registered from the check
// state that follows the start edge. Otherwise an item runs one pass per Racah term and
// then the normalization and square root, the time of a term depending on how far the
// running sum must be aligned and normalized; all the arithmetic goes through the
// single shared floating-point unit, which resolves one mantissa bit per cycle for
// multiply, divide and square root and aligns and normalizes sums one bit position
// per cycle.

`include "clebsch_gordan_coefficient_macros.svh"

module clebsch_gordan_coefficient import cgc_pkg::*; #(
	parameter int FACT_ENTRIES = FACT_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [4:0]  two_j1,
	input  wire logic [4:0]  two_j2,
	input  wire logic [5:0]  two_total_j,
	input  wire logic signed [5:0] two_m1,
	input  wire logic signed [5:0] two_m2,
	input  wire logic signed [6:0] two_total_m,
	output logic             done,
	output logic [63:0]      coefficient_bits
);

	localparam int AW = $clog2(FACT_ENTRIES);
	localparam logic [AW-1:0] K_LAST = AW'(FACT_ENTRIES - 1);

	seq_st_t st_q, st_d;
	pc_t     pc_q;
	logic [AW-1:0] k_q;
	logic          done_q;

	// Transaction inputs, held for the whole item
	logic [4:0] j1_q, j2_q;
	logic [5:0] tj_q;
	logic [5:0] m1_q, m2_q;
	logic [6:0] tm_q;

	logic signed [8:0] nu_q, numax_q;
	logic [63:0] x_q, y_q, sum_q, coef_q;

	fpu_ctl_t    fpu_ctl;
	fpu_sts_t    fpu_sts;
	logic [63:0] fpu_a, fpu_b, fpu_res;

	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [63:0]   ram_wdata, ram_rdata;

	logic signed [8:0] j1s, j2s, tjs, m1s, m2s, tms, gap;
	logic signed [8:0] hn1, hn2, hd1, hd2, hd3, na, nc, ne, dp, dr, ds, dt;
	logic signed [8:0] nu_start, nu_max, arg;
	logic        ok, neg, to_y, wr_now;
	uop_t        uop;
	logic [63:0] wr_val;

	function automatic logic [63:0] int_to_dbl(input logic [6:0] k);
		logic [2:0]  p;
		logic [52:0] sh;
		p = 3'd0;
		for (int i = 0; i < 7; i++) begin
			if (k[i]) p = 3'(i);
		end
		sh = {46'd0, k} << (6'd52 - {3'd0, p});
		return {1'b0, 11'd1023 + {8'd0, p}, sh[51:0]};
	endfunction

	cgc_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (fpu_ctl),
		.opa    (fpu_a),
		.opb    (fpu_b),
		.sts    (fpu_sts),
		.res    (fpu_res)
	);

	cgc_ram #(
		.WIDTH (DBL_W),
		.DEPTH (FACT_ENTRIES)
	) u_fact (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Half-sums of the Racah formula; exact whenever the selection rules hold
	always_comb begin
		j1s = $signed({4'd0, j1_q});
		j2s = $signed({4'd0, j2_q});
		tjs = $signed({3'd0, tj_q});
		m1s = $signed({{3{m1_q[5]}}, m1_q});
		m2s = $signed({{3{m2_q[5]}}, m2_q});
		tms = $signed({{2{tm_q[6]}}, tm_q});
		gap = (j1s >= j2s) ? j1s - j2s : j2s - j1s;
		hn1 = (j2s + tjs + m1s) >>> 1;
		hn2 = (j1s - m1s) >>> 1;
		hd1 = (tjs - j1s + j2s) >>> 1;
		hd2 = (tjs + tms) >>> 1;
		hd3 = (j1s - j2s - tms) >>> 1;
		na  = (tjs + j1s - j2s) >>> 1;
		nc  = (j1s + j2s - tjs) >>> 1;
		ne  = (tjs - tms) >>> 1;
		dp  = ((j1s + j2s + tjs) >>> 1) + 9'sd1;
		dr  = (j1s + m1s) >>> 1;
		ds  = (j2s - m2s) >>> 1;
		dt  = (j2s + m2s) >>> 1;

		ok = (m1s + m2s == tms)
		  && !(m1s > j1s) && !(-m1s > j1s)
		  && !(m2s > j2s) && !(-m2s > j2s)
		  && !(tms > tjs) && !(-tms > tjs)
		  && !(tjs > j1s + j2s) && !(tjs < gap)
		  && !((j1_q[0] ^ m1_q[0]) | (j2_q[0] ^ m2_q[0]) | (j1_q[0] ^ j2_q[0] ^ tj_q[0]));

		// First nu with both rising factorial arguments non-negative
		nu_start = 9'sd0;
		if (-hd3 > nu_start) nu_start = -hd3;
		if (-hn2 > nu_start) nu_start = -hn2;
		// Last nu with all falling factorial arguments non-negative
		nu_max = hd1;
		if (hd2 < nu_max) nu_max = hd2;
		if (hn1 < nu_max) nu_max = hn1;

		// Sign of the term alternates with nu
		neg = nu_q[0] ^ dt[0];
	end

	// Microprogram decode: factorial argument, operation and destination of each step
	always_comb begin
		arg  = nu_q;
		uop  = U_MULF;
		to_y = 1'b0;
		unique case (pc_q)
			P_T_N1:   begin arg = hn1 - nu_q; uop = U_LDF; end
			P_T_N2:   arg = hn2 + nu_q;
			P_T_NU:   begin arg = nu_q; uop = U_LDF; to_y = 1'b1; end
			P_T_D1:   begin arg = hd1 - nu_q; to_y = 1'b1; end
			P_T_D2:   begin arg = hd2 - nu_q; to_y = 1'b1; end
			P_T_D3:   begin arg = hd3 + nu_q; to_y = 1'b1; end
			P_T_DIV:  uop = U_DIV;
			P_T_ADD:  uop = U_ADD;
			P_N_INT:  uop = U_LDI;
			P_N_A:    arg = na;
			P_N_B:    arg = hd1;
			P_N_C:    arg = nc;
			P_N_D:    arg = hd2;
			P_N_E:    arg = ne;
			P_D_P:    begin arg = dp; uop = U_LDF; to_y = 1'b1; end
			P_D_Q:    begin arg = hn2; to_y = 1'b1; end
			P_D_R:    begin arg = dr; to_y = 1'b1; end
			P_D_S:    begin arg = ds; to_y = 1'b1; end
			P_D_T:    begin arg = dt; to_y = 1'b1; end
			P_N_DIV:  uop = U_DIV;
			P_N_SQRT: uop = U_SQRT;
			P_N_MUL:  uop = U_MULS;
			default:  uop = U_LDI;
		endcase
	end

	// Step completes on a direct load or when the shared unit hands back its result
	always_comb begin
		wr_now = ((st_q == S_OPER) && ((uop == U_LDF) || (uop == U_LDI)))
		      || ((st_q == S_WAIT) && fpu_sts.done);
		if (st_q == S_WAIT) begin
			wr_val = fpu_res;
		end else if (uop == U_LDI) begin
			wr_val = int_to_dbl(tj_q + 7'd1);
		end else begin
			wr_val = {ram_rdata[63] ^ (neg && (pc_q == P_T_N1)), ram_rdata[62:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_INIT_ZERO;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d      = st_q;
		fpu_ctl   = '{go: 1'b0, op: FOP_MUL};
		fpu_a     = x_q;
		fpu_b     = ram_rdata;
		ram_we    = 1'b0;
		ram_waddr = k_q;
		ram_wdata = fpu_res;
		ram_raddr = arg[AW-1:0];
		unique case (st_q)
			S_INIT_ZERO: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = DBL_ONE;
				st_d      = S_INIT_GO;
			end
			S_INIT_GO: begin
				fpu_ctl = '{go: 1'b1, op: FOP_MUL};
				fpu_a   = int_to_dbl(7'(k_q));
				fpu_b   = x_q;
				st_d    = S_INIT_WAIT;
			end
			S_INIT_WAIT: begin
				if (fpu_sts.done) begin
					ram_we = 1'b1;
					st_d   = (k_q == K_LAST) ? S_IDLE : S_INIT_GO;
				end
			end
			S_IDLE:  if (start) st_d = S_CHECK;
			S_CHECK: st_d = ok ? S_FETCH : S_IDLE;
			S_FETCH: st_d = S_OPER;
			S_OPER: begin
				unique case (uop)
					U_LDF, U_LDI: st_d = (pc_q == P_N_MUL) ? S_IDLE : S_FETCH;
					U_MULF: begin
						fpu_ctl = '{go: 1'b1, op: FOP_MUL};
						fpu_a   = to_y ? y_q : x_q;
						st_d    = S_WAIT;
					end
					U_DIV: begin
						fpu_ctl = '{go: 1'b1, op: FOP_DIV};
						fpu_b   = y_q;
						st_d    = S_WAIT;
					end
					U_ADD: begin
						fpu_ctl = '{go: 1'b1, op: FOP_ADD};
						fpu_a   = sum_q;
						fpu_b   = x_q;
						st_d    = S_WAIT;
					end
					U_SQRT: begin
						fpu_ctl = '{go: 1'b1, op: FOP_SQRT};
						st_d    = S_WAIT;
					end
					U_MULS: begin
						fpu_ctl = '{go: 1'b1, op: FOP_MUL};
						fpu_b   = sum_q;
						st_d    = S_WAIT;
					end
					default: st_d = S_IDLE;
				endcase
			end
			S_WAIT: begin
				if (fpu_sts.done) st_d = (pc_q == P_N_MUL) ? S_IDLE : S_FETCH;
			end
			default: st_d = S_IDLE;
		endcase
	end

	// Sequencer control: table build counter, step pointer, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= '0;
			pc_q   <= P_T_N1;
			done_q <= 1'b0;
		end else begin
			done_q <= ((st_q == S_CHECK) && !ok) || (wr_now && (pc_q == P_N_MUL));
			if (st_q == S_INIT_ZERO) begin
				k_q <= AW'(1);
			end else if ((st_q == S_INIT_WAIT) && fpu_sts.done && (k_q != K_LAST)) begin
				k_q <= k_q + AW'(1);
			end
			if ((st_q == S_CHECK) && ok) begin
				pc_q <= (nu_start > nu_max) ? P_N_INT : P_T_N1;
			end else if (wr_now) begin
				if (pc_q == P_T_ADD) begin
					pc_q <= (nu_q == numax_q) ? P_N_INT : P_T_N1;
				end else if (pc_q != P_N_MUL) begin
					pc_q <= pc_t'(5'(pc_q) + 5'd1);
				end
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if ((st_q == S_IDLE) && start) begin
			j1_q <= two_j1;
			j2_q <= two_j2;
			tj_q <= two_total_j;
			m1_q <= two_m1;
			m2_q <= two_m2;
			tm_q <= two_total_m;
		end
		if (st_q == S_INIT_ZERO) begin
			x_q <= DBL_ONE;
		end else if ((st_q == S_INIT_WAIT) && fpu_sts.done) begin
			x_q <= fpu_res;
		end
		if (st_q == S_CHECK) begin
			nu_q    <= nu_start;
			numax_q <= nu_max;
			sum_q   <= '0;
			coef_q  <= '0;
		end
		if (wr_now) begin
			if (pc_q == P_T_ADD) begin
				sum_q <= wr_val;
				nu_q  <= nu_q + 9'sd1;
			end else if (to_y) begin
				y_q <= wr_val;
			end else begin
				x_q <= wr_val;
			end
			if (pc_q == P_N_MUL) coef_q <= wr_val;
		end
	end

	assign busy             = (st_q != S_IDLE);
	assign done             = done_q;
	assign coefficient_bits = coef_q;

	`CGC_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "accepted transaction did not raise busy")
	`CGC_ASSERT_NOW(a_done_idle, clk, arst_n, done, !busy, "result strobe while still busy")
	`CGC_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done, "result strobe longer than one cycle")
	`CGC_ASSERT_NOW(a_fpu_go_idle, clk, arst_n, fpu_ctl.go, fpu_sts.idle, "arithmetic unit started while working")

endmodule

`default_nettype wire
